FILE: rtl/psm_pkg.sv
// ============================================================================
// psm_pkg: shared types and constants of the match table
// Slot count, reserved ids, opcode and status codes, and the slot entry type.
// ============================================================================
`default_nettype none

package psm_pkg;

    localparam int SLOTS       = 32;
    localparam int MAX_RESULTS = 32;

    // used count holds 0..SLOTS, slot index holds 0..SLOTS-1
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int HIT_W = $clog2(MAX_RESULTS + 1);

    localparam logic [31:0] ID_ALL   = 32'hFFFF_FFFF;
    localparam logic [31:0] ID_ACK   = 32'hFFFF_FFFE;
    localparam logic [31:0] ID_ROUTE = 32'hFFFF_FFFD;

    typedef enum logic [1:0] {
        OP_SUBSCRIBE   = 2'd0,
        OP_UNSUBSCRIBE = 2'd1,
        OP_PUBLISH     = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_DELIVER = 3'd0,
        ST_ACK     = 3'd1,
        ST_UNSUB   = 3'd2,
        ST_REJECT  = 3'd3,
        ST_NOMATCH = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [31:0] owner;
        logic [31:0] topic;
        logic        wild;
        logic        active;
    } entry_t;

    // controller to the cell chain: rotate enable and the entry fed at the tail
    typedef struct packed {
        logic   shift;
        entry_t tail;
    } chain_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/psm_req_if.sv
// ============================================================================
// psm_req_if: request channel
// Valid/ready channel carrying one subscribe, unsubscribe or publish word.
// ============================================================================
`default_nettype none

interface psm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] message_id;
    logic [31:0] subscriber_id;
    logic [63:0] payload;

    modport source (output valid, opcode, message_id, subscriber_id, payload, input ready);
    modport sink   (input valid, opcode, message_id, subscriber_id, payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/psm_rsp_if.sv
// ============================================================================
// psm_rsp_if: result channel
// Valid/ready channel carrying one delivery, acknowledgement or status word.
// ============================================================================
`default_nettype none

interface psm_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] target_id;
    logic [31:0] delivered_id;
    logic [63:0] delivered_payload;
    logic        last;

    modport source (output valid, status, target_id, delivered_id, delivered_payload, last,
                    input ready);
    modport sink   (input valid, status, target_id, delivered_id, delivered_payload, last,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/publish_subscribe_match_table.sv
// A command passes through accept, one full rotation of the SLOTS-cell chain
// and a final result; rejected commands (reserved ids, undefined opcodes) skip
// the rotation. Commands are taken one at a time; a stalled result port pauses
// the rotation only when a further delivery waits.
// Reset: all slots inactive, used count zero, next id one; entry data is not
// cleared and no clearing pass runs.
// ============================================================================
// publish_subscribe_match_table: subscription table with publish fan-out
// A ring of slot cells rotates past a head sequencer that matches and edits.
// ============================================================================
`default_nettype none

module publish_subscribe_match_table
    import psm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    psm_req_if.sink    request,
    psm_rsp_if.source  response
);

    entry_t     link [SLOTS];
    chain_ctl_t chain;

    psm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (request),
        .rsp   (response),
        .head  (link[0]),
        .chain (chain)
    );

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        entry_t feed;
        if (i == SLOTS - 1)
        begin : g_tail
            assign feed = chain.tail;
        end
        else
        begin : g_mid
            assign feed = link[i + 1];
        end

        psm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (chain.shift),
            .entry_in  (feed),
            .entry_out (link[i])
        );
    end

endmodule

`default_nettype wire

FILE: rtl/psm_cell.sv
// ============================================================================
// psm_cell: one subscription slot of the rotating chain
// Holds one entry and takes its neighbor's entry whenever the chain shifts.
// ============================================================================
`default_nettype none

module psm_cell
    import psm_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   shift,
    input  entry_t      entry_in,
    output entry_t      entry_out
);

    logic        active_reg;
    logic [31:0] owner_reg;
    logic [31:0] topic_reg;
    logic        wildcard_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (shift)
        begin
            active_reg <= entry_in.active;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            owner_reg    <= entry_in.owner;
            topic_reg    <= entry_in.topic;
            wildcard_reg <= entry_in.wild;
        end
    end

    assign entry_out = '{owner: owner_reg, topic: topic_reg,
                         wild: wildcard_reg, active: active_reg};

endmodule

`default_nettype wire

FILE: rtl/psm_ctrl.sv
// ============================================================================
// psm_ctrl: command sequencer at the head of the cell chain
// Rotates the table once per command that is not rejected, edits the head entry on its way to the
// tail, and queues results through a one-deep lookahead and an output register.
// ============================================================================
`default_nettype none

module psm_ctrl
    import psm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    psm_req_if.sink    req,
    psm_rsp_if.source  rsp,
    input  entry_t     head,
    output chain_ctl_t chain
);

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   rot_reg, rot_next;
    logic [CNT_W-1:0]   used_reg, used_next;
    logic [31:0]        owner_ctr_reg, owner_ctr_next;
    logic [HIT_W-1:0]   hit_reg, hit_next;
    logic               done_reg, done_next;
    logic               rej_reg, rej_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [31:0]        pend_target_reg, pend_target_next;
    logic [31:0]        ack_id_reg, ack_id_next;

    logic [1:0]         op_reg, op_next;
    logic [31:0]        mid_reg, mid_next;
    logic [31:0]        sid_reg, sid_next;
    logic [63:0]        pay_reg, pay_next;

    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [31:0]        out_target_reg, out_target_next;
    logic [31:0]        out_mid_reg, out_mid_next;
    logic [63:0]        out_pay_reg, out_pay_next;
    logic               out_last_reg, out_last_next;

    logic               out_free;
    logic               in_range;
    logic               at_append;
    logic               match;
    logic               stall;
    logic               rejected_now;
    logic [31:0]        owner_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rot_reg        <= '0;
            used_reg       <= '0;
            owner_ctr_reg  <= 32'd1;
            hit_reg        <= '0;
            done_reg       <= 1'b0;
            rej_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rot_reg        <= rot_next;
            used_reg       <= used_next;
            owner_ctr_reg  <= owner_ctr_next;
            hit_reg        <= hit_next;
            done_reg       <= done_next;
            rej_reg        <= rej_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        mid_reg         <= mid_next;
        sid_reg         <= sid_next;
        pay_reg         <= pay_next;
        pend_target_reg <= pend_target_next;
        ack_id_reg      <= ack_id_next;
        out_status_reg  <= out_status_next;
        out_target_reg  <= out_target_next;
        out_mid_reg     <= out_mid_next;
        out_pay_reg     <= out_pay_next;
        out_last_reg    <= out_last_next;
    end

    assign out_free  = !out_valid_reg || rsp.ready;
    assign in_range  = CNT_W'(rot_reg) < used_reg;
    assign at_append = CNT_W'(rot_reg) == used_reg;
    assign match     = in_range && head.active && (head.wild || head.topic == mid_reg)
                       && (hit_reg < HIT_W'(MAX_RESULTS));
    assign owner_inc = owner_ctr_reg + 32'd1;

    always_comb
    begin
        state_next       = state_reg;
        rot_next         = rot_reg;
        used_next        = used_reg;
        owner_ctr_next   = owner_ctr_reg;
        hit_next         = hit_reg;
        done_next        = done_reg;
        rej_next         = rej_reg;
        pend_valid_next  = pend_valid_reg;
        pend_target_next = pend_target_reg;
        ack_id_next      = ack_id_reg;
        op_next          = op_reg;
        mid_next         = mid_reg;
        sid_next         = sid_reg;
        pay_next         = pay_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_target_next  = out_target_reg;
        out_mid_next     = out_mid_reg;
        out_pay_next     = out_pay_reg;
        out_last_next    = out_last_reg;
        chain.shift      = 1'b0;
        chain.tail       = head;
        req.ready        = 1'b0;
        stall            = 1'b0;
        rejected_now     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    op_next         = req.opcode;
                    mid_next        = req.message_id;
                    sid_next        = req.subscriber_id;
                    pay_next        = req.payload;
                    rot_next        = '0;
                    hit_next        = '0;
                    done_next       = 1'b0;
                    pend_valid_next = 1'b0;
                    case (req.opcode)
                        OP_SUBSCRIBE:   rejected_now = (req.message_id == ID_ROUTE);
                        OP_UNSUBSCRIBE: rejected_now = 1'b0;
                        OP_PUBLISH:     rejected_now = (req.message_id == ID_ALL)
                                                       || (req.message_id == ID_ACK)
                                                       || (req.message_id == ID_ROUTE);
                        default:        rejected_now = 1'b1;
                    endcase
                    rej_next   = rejected_now;
                    state_next = rejected_now ? S_FINISH : S_SCAN;
                end
            end

            S_SCAN:
            begin
                case (op_reg)
                    OP_SUBSCRIBE:
                    begin
                        // first free slot below the used count, else append
                        if (!done_reg && ((in_range && !head.active) || at_append))
                        begin
                            chain.tail     = '{owner: owner_ctr_reg, topic: mid_reg,
                                               wild: (mid_reg == ID_ALL), active: 1'b1};
                            done_next      = 1'b1;
                            ack_id_next    = owner_ctr_reg;
                            owner_ctr_next = (owner_inc == 32'd0) ? 32'd1 : owner_inc;
                            if (at_append)
                            begin
                                used_next = used_reg + CNT_W'(1);
                            end
                        end
                    end
                    OP_UNSUBSCRIBE:
                    begin
                        if (!done_reg && sid_reg != 32'd0 && in_range && head.owner == sid_reg)
                        begin
                            chain.tail.active = 1'b0;
                            done_next         = 1'b1;
                        end
                    end
                    OP_PUBLISH:
                    begin
                        // hold the previous hit until the next one shows it was not last
                        stall = match && pend_valid_reg && !out_free;
                        if (match && !stall)
                        begin
                            hit_next         = hit_reg + HIT_W'(1);
                            pend_valid_next  = 1'b1;
                            pend_target_next = head.owner;
                            if (pend_valid_reg)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_DELIVER;
                                out_target_next = pend_target_reg;
                                out_mid_next    = mid_reg;
                                out_pay_next    = pay_reg;
                                out_last_next   = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                        stall = 1'b0;
                    end
                endcase

                if (!stall)
                begin
                    chain.shift = 1'b1;
                    rot_next    = rot_reg + IDX_W'(1);
                    if (rot_reg == IDX_W'(SLOTS - 1))
                    begin
                        rot_next   = '0;
                        state_next = S_FINISH;
                    end
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    out_status_next = ST_REJECT;
                    out_target_next = 32'd0;
                    out_mid_next    = 32'd0;
                    out_pay_next    = 64'd0;
                    if (!rej_reg)
                    begin
                        case (op_reg)
                            OP_SUBSCRIBE:
                            begin
                                // no slot found means the table is full
                                if (done_reg)
                                begin
                                    out_status_next = ST_ACK;
                                    out_target_next = ack_id_reg;
                                    out_mid_next    = ID_ACK;
                                    out_pay_next    = {32'd0, ack_id_reg};
                                end
                            end
                            OP_UNSUBSCRIBE:
                            begin
                                out_status_next = ST_UNSUB;
                                out_target_next = sid_reg;
                            end
                            OP_PUBLISH:
                            begin
                                out_status_next = pend_valid_reg ? ST_DELIVER : ST_NOMATCH;
                                out_target_next = pend_valid_reg ? pend_target_reg : 32'd0;
                                out_mid_next    = mid_reg;
                                out_pay_next    = pay_reg;
                            end
                            default:
                            begin
                                out_status_next = ST_REJECT;
                            end
                        endcase
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.status            = out_status_reg;
    assign rsp.target_id         = out_target_reg;
    assign rsp.delivered_id      = out_mid_reg;
    assign rsp.delivered_payload = out_pay_reg;
    assign rsp.last              = out_last_reg;

endmodule

`default_nettype wire

FILE: rtl/psm_checker.sv
// ============================================================================
// psm_checker: port-level checks of the match table
// Result hold under stall, one command at a time, and result word shape.
// ============================================================================
`default_nettype none

module psm_checker
    import psm_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [2:0]  rsp_status,
    input wire logic [31:0] rsp_target_id,
    input wire logic [31:0] rsp_delivered_id,
    input wire logic [63:0] rsp_delivered_payload,
    input wire logic        rsp_last
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_target_id) && $stable(rsp_last))
        else $error("result word changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second command taken while one is in flight");

    a_ack_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_ACK |-> rsp_target_id != 32'd0
            && rsp_delivered_id == ID_ACK && rsp_delivered_payload[31:0] == rsp_target_id)
        else $error("malformed acknowledgement");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_DELIVER |-> rsp_last)
        else $error("non-delivery result not marked last");

endmodule

bind publish_subscribe_match_table psm_checker u_psm_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .req_valid             (request.valid),
    .req_ready             (request.ready),
    .rsp_valid             (response.valid),
    .rsp_ready             (response.ready),
    .rsp_status            (response.status),
    .rsp_target_id         (response.target_id),
    .rsp_delivered_id      (response.delivered_id),
    .rsp_delivered_payload (response.delivered_payload),
    .rsp_last              (response.last)
);

`default_nettype wire
